FILE: design/sfuv_pkg.sv
// Shared widths, register indexes, reset values and helpers of the sprite frame UV stepper.
`timescale 1ns / 1ps

package sfuv_pkg;

  localparam int unsigned DimW     = 13;
  localparam int unsigned PosW     = 12;
  localparam int unsigned CountW   = 9;
  localparam int unsigned PeriodW  = 16;
  localparam int unsigned AccW     = 17;
  localparam int unsigned FrameW   = 8;
  localparam int unsigned CmdW     = 1;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned MaxFrames = 256;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned UvW       = FracBits + 1;
  localparam int unsigned EffCap    = (MaxFrames < 256) ? MaxFrames : 256;

  localparam int unsigned XW     = DimW + FrameW;
  localparam int unsigned RowW   = XW;
  localparam int unsigned YW     = DimW + RowW;
  localparam int unsigned CoordW = YW + 1;

  localparam logic [UvW-1:0]  UvSat    = {UvW{1'b1}};
  localparam logic [AccW-1:0] TickStep = AccW'(16);

  localparam logic [CmdW-1:0] CmdTick = 1'b0;
  localparam logic [CmdW-1:0] CmdSet  = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TEX_WIDTH    = 3'd0,
    CFG_TEX_HEIGHT   = 3'd1,
    CFG_SOURCE_X     = 3'd2,
    CFG_SOURCE_Y     = 3'd3,
    CFG_STEP_X       = 3'd4,
    CFG_STEP_Y       = 3'd5,
    CFG_FRAME_COUNT  = 3'd6,
    CFG_FRAME_PERIOD = 3'd7
  } cfg_idx_e;

  localparam logic [DimW-1:0]    RstTexWidth  = DimW'(256);
  localparam logic [DimW-1:0]    RstTexHeight = DimW'(256);
  localparam logic [PosW-1:0]    RstSourceX   = '0;
  localparam logic [PosW-1:0]    RstSourceY   = '0;
  localparam logic [DimW-1:0]    RstStepX     = DimW'(16);
  localparam logic [DimW-1:0]    RstStepY     = DimW'(16);
  localparam logic [CountW-1:0]  RstCount     = CountW'(1);
  localparam logic [PeriodW-1:0] RstPeriod    = PeriodW'(16);

  // Number of frames actually in use for a programmed count.
  function automatic logic [CountW-1:0] eff_count(input logic [CountW-1:0] cnt);
    logic [CountW-1:0] res;
    res = cnt;
    if (cnt == '0) begin
      res = CountW'(1);
    end else if (cnt > CountW'(EffCap)) begin
      res = CountW'(EffCap);
    end
    return res;
  endfunction

endpackage

FILE: design/sfuv_in_if.sv
// Input channel interface of the sprite frame UV stepper.
`timescale 1ns / 1ps

interface sfuv_in_if;
  logic                          valid;
  logic                          ready;
  logic [sfuv_pkg::CmdW-1:0]     command;
  logic [sfuv_pkg::FrameW-1:0]   frame_index;

  modport source (output valid, output command, output frame_index, input ready);
  modport sink (input valid, input command, input frame_index, output ready);
endinterface

FILE: design/sfuv_out_if.sv
// Result channel interface of the sprite frame UV stepper.
`timescale 1ns / 1ps

interface sfuv_out_if;
  logic                        valid;
  logic                        ready;
  logic [sfuv_pkg::FrameW-1:0] frame;
  logic                        frame_changed;
  logic [sfuv_pkg::UvW-1:0]    u_min;
  logic [sfuv_pkg::UvW-1:0]    u_max;
  logic [sfuv_pkg::UvW-1:0]    v_min;
  logic [sfuv_pkg::UvW-1:0]    v_max;

  modport source (output valid, output frame, output frame_changed, output u_min,
                  output u_max, output v_min, output v_max, input ready);
  modport sink (input valid, input frame, input frame_changed, input u_min,
                input u_max, input v_min, input v_max, output ready);
endinterface

FILE: design/sfuv_div.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module sfuv_div #(
  parameter int unsigned NumW = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [NumW-1:0]           num_i,
  input  logic [sfuv_pkg::DimW-1:0] rem_i,
  input  logic [sfuv_pkg::DimW-1:0] den_i,
  output logic [NumW-1:0]           quo_o,
  output logic [sfuv_pkg::DimW-1:0] rem_o,
  output logic                      done_o
);

  localparam int unsigned DenW = sfuv_pkg::DimW;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [CntW-1:0] cnt_q;
  logic            done_q;
  logic [NumW-1:0] nq_q;
  logic [DenW-1:0] rem_q;
  logic [DenW-1:0] den_q;

  logic [DenW:0]   trial;
  logic [DenW:0]   diff;
  logic            ge;
  logic [DenW-1:0] rem_d;

  assign trial = {rem_q, nq_q[NumW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};
  assign rem_d = ge ? diff[DenW-1:0] : trial[DenW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      if (start_i) begin
        cnt_q  <= CntW'(NumW);
        done_q <= 1'b0;
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - CntW'(1);
        done_q <= (cnt_q == CntW'(1));
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nq_q  <= num_i;
      rem_q <= rem_i;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      nq_q  <= {nq_q[NumW-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign quo_o  = nq_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

FILE: design/sprite_frame_uv_stepper_unit.sv
// Top level of the sprite frame UV stepper: frame state, serial arithmetic and result register.
`timescale 1ns / 1ps

//  Channel   Dir  Payload                                            Handshake
//  in_ch     in   command, frame_index                               valid / ready
//  out_ch    out  frame, frame_changed, u_min, u_max, v_min, v_max   valid / ready
//  cfg       in   cfg_idx_i, cfg_wdata_i                             cfg_we_i
//
// After a transaction is accepted, in_ch.ready returns once its result has entered the output
// register; the row divider is skipped when the texture width is zero.
// The work is done by the bit-serial shift-add multiplier (8 then 21 steps), the row
// divider (21 steps) and the four UV dividers (16 steps, running in parallel).
// A finished result waits in the output register, and the next transaction is taken
// meanwhile; only the hand-over into a still full output register stalls the block.
// Reset is asynchronous and restores the register defaults, frame 0 and accumulator 0.

module sprite_frame_uv_stepper_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sfuv_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sfuv_pkg::CfgDataW-1:0]  cfg_wdata_i,
  sfuv_in_if.sink                        in_ch,
  sfuv_out_if.source                     out_ch
);

  localparam int unsigned DimW    = sfuv_pkg::DimW;
  localparam int unsigned PosW    = sfuv_pkg::PosW;
  localparam int unsigned CountW  = sfuv_pkg::CountW;
  localparam int unsigned PeriodW = sfuv_pkg::PeriodW;
  localparam int unsigned AccW    = sfuv_pkg::AccW;
  localparam int unsigned FrameW  = sfuv_pkg::FrameW;
  localparam int unsigned XW      = sfuv_pkg::XW;
  localparam int unsigned RowW    = sfuv_pkg::RowW;
  localparam int unsigned YW      = sfuv_pkg::YW;
  localparam int unsigned CoordW  = sfuv_pkg::CoordW;
  localparam int unsigned UvW     = sfuv_pkg::UvW;
  localparam int unsigned FracW   = sfuv_pkg::FracBits;
  localparam int unsigned McntW   = $clog2(RowW + 1);
  localparam int unsigned Lanes   = 4;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MULX  = 3'd1;
  localparam logic [2:0] ST_DIVR  = 3'd2;
  localparam logic [2:0] ST_MULY  = 3'd3;
  localparam logic [2:0] ST_PREP  = 3'd4;
  localparam logic [2:0] ST_DIVUV = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [DimW-1:0]    tex_w_q;
  logic [DimW-1:0]    tex_h_q;
  logic [PosW-1:0]    src_x_q;
  logic [PosW-1:0]    src_y_q;
  logic [DimW-1:0]    step_x_q;
  logic [DimW-1:0]    step_y_q;
  logic [CountW-1:0]  fcount_q;
  logic [PeriodW-1:0] period_q;

  logic [FrameW-1:0]  frame_q;
  logic [AccW-1:0]    acc_q;
  logic               changed_q;

  logic [2:0]         state_q;
  logic [McntW-1:0]   mcnt_q;
  logic [DimW-1:0]    mul_hi_q;
  logic [RowW-1:0]    mul_lo_q;
  logic [XW-1:0]      x_q;
  logic [YW-1:0]      y_q;
  logic [Lanes-1:0]   sat_q;
  logic [Lanes-1:0]   msb_q;

  logic               out_valid_q;
  logic [FrameW-1:0]  o_frame_q;
  logic               o_changed_q;
  logic [UvW-1:0]     o_uv_q [Lanes];

  logic               in_fire;
  logic [CountW-1:0]  eff_cnt;
  logic [AccW-1:0]    acc_inc;
  logic               adv;
  logic [CountW-1:0]  frame_inc;
  logic [FrameW-1:0]  frame_wrap;
  logic               set_ok;
  logic [FrameW-1:0]  frame_d;
  logic [AccW-1:0]    acc_d;
  logic               chg_d;

  logic [DimW-1:0]    mul_mcand;
  logic [DimW:0]      mul_sum;
  logic               mul_step;
  logic [XW-1:0]      x_sum;
  logic [YW-1:0]      y_sum;

  logic               row_start;
  logic [RowW-1:0]    row_quo;
  logic [DimW-1:0]    row_rem;
  logic               row_done;

  logic [CoordW-1:0]  coord [Lanes];
  logic [DimW-1:0]    dim [Lanes];
  logic [Lanes-1:0]   ge_d;
  logic [Lanes-1:0]   sat_d;
  logic [DimW-1:0]    rem_init [Lanes];
  logic [FracW-1:0]   uv_quo [Lanes];
  logic [Lanes-1:0]   uv_done;
  logic               out_load;

  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_q == ST_IDLE);

  // Frame and accumulator update for the accepted transaction.
  assign eff_cnt    = sfuv_pkg::eff_count(fcount_q);
  assign acc_inc    = acc_q + sfuv_pkg::TickStep;
  assign adv        = acc_inc >= {1'b0, period_q};
  assign frame_inc  = {1'b0, frame_q} + CountW'(1);
  assign frame_wrap = (frame_inc >= eff_cnt) ? '0 : frame_inc[FrameW-1:0];
  assign set_ok     = {1'b0, in_ch.frame_index} < eff_cnt;

  always_comb begin
    frame_d = frame_q;
    acc_d   = acc_q;
    chg_d   = 1'b0;
    if (in_ch.command == sfuv_pkg::CmdSet) begin
      if (set_ok) begin
        frame_d = in_ch.frame_index;
        chg_d   = 1'b1;
      end
    end else if (eff_cnt > CountW'(1)) begin
      if (adv) begin
        acc_d   = acc_inc - {1'b0, period_q};
        frame_d = frame_wrap;
        chg_d   = 1'b1;
      end else begin
        acc_d = acc_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_w_q  <= sfuv_pkg::RstTexWidth;
      tex_h_q  <= sfuv_pkg::RstTexHeight;
      src_x_q  <= sfuv_pkg::RstSourceX;
      src_y_q  <= sfuv_pkg::RstSourceY;
      step_x_q <= sfuv_pkg::RstStepX;
      step_y_q <= sfuv_pkg::RstStepY;
      fcount_q <= sfuv_pkg::RstCount;
      period_q <= sfuv_pkg::RstPeriod;
    end else if (cfg_we_i) begin
      unique case (sfuv_pkg::cfg_idx_e'(cfg_idx_i))
        sfuv_pkg::CFG_TEX_WIDTH:    tex_w_q  <= cfg_wdata_i[DimW-1:0];
        sfuv_pkg::CFG_TEX_HEIGHT:   tex_h_q  <= cfg_wdata_i[DimW-1:0];
        sfuv_pkg::CFG_SOURCE_X:     src_x_q  <= cfg_wdata_i[PosW-1:0];
        sfuv_pkg::CFG_SOURCE_Y:     src_y_q  <= cfg_wdata_i[PosW-1:0];
        sfuv_pkg::CFG_STEP_X:       step_x_q <= cfg_wdata_i[DimW-1:0];
        sfuv_pkg::CFG_STEP_Y:       step_y_q <= cfg_wdata_i[DimW-1:0];
        sfuv_pkg::CFG_FRAME_COUNT:  fcount_q <= cfg_wdata_i[CountW-1:0];
        sfuv_pkg::CFG_FRAME_PERIOD: period_q <= cfg_wdata_i[PeriodW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
      acc_q   <= '0;
    end else if (in_fire) begin
      frame_q <= frame_d;
      acc_q   <= acc_d;
    end else if (cfg_we_i
                 && (sfuv_pkg::cfg_idx_e'(cfg_idx_i) == sfuv_pkg::CFG_FRAME_COUNT)
                 && ({1'b0, frame_q} >= sfuv_pkg::eff_count(cfg_wdata_i[CountW-1:0]))) begin
      frame_q <= '0;
    end
  end

  // Shared shift-add multiplier: one multiplier bit per cycle, LSB first.
  assign mul_mcand = (state_q == ST_MULX) ? step_x_q : step_y_q;
  assign mul_sum   = {1'b0, mul_hi_q} + (mul_lo_q[0] ? {1'b0, mul_mcand} : '0);
  assign mul_step  = ((state_q == ST_MULX) || (state_q == ST_MULY)) && (mcnt_q != '0);
  assign x_sum     = {mul_hi_q, mul_lo_q[RowW-1 -: FrameW]} + XW'(src_x_q);
  assign y_sum     = {mul_hi_q, mul_lo_q} + YW'(src_y_q);

  assign row_start = (state_q == ST_MULX) && (mcnt_q == '0) && (tex_w_q != '0);

  sfuv_div #(.NumW(RowW)) u_row_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (row_start),
    .num_i   (x_sum),
    .rem_i   ('0),
    .den_i   (tex_w_q),
    .quo_o   (row_quo),
    .rem_o   (row_rem),
    .done_o  (row_done)
  );

  // Each UV quotient saturates when the coordinate reaches twice the dimension or the dimension is zero.
  always_comb begin
    coord[0] = CoordW'(x_q);
    coord[1] = CoordW'(x_q) + CoordW'(step_x_q);
    coord[2] = CoordW'(y_q);
    coord[3] = CoordW'(y_q) + CoordW'(step_y_q);
    dim[0]   = tex_w_q;
    dim[1]   = tex_w_q;
    dim[2]   = tex_h_q;
    dim[3]   = tex_h_q;
    for (int l = 0; l < Lanes; l++) begin
      ge_d[l]     = coord[l] >= CoordW'(dim[l]);
      sat_d[l]    = (dim[l] == '0) || (coord[l] >= (CoordW'(dim[l]) << 1));
      rem_init[l] = ge_d[l] ? DimW'(coord[l] - CoordW'(dim[l])) : coord[l][DimW-1:0];
    end
  end

  for (genvar l = 0; l < Lanes; l++) begin : g_uv
    sfuv_div #(.NumW(FracW)) u_uv_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (state_q == ST_PREP),
      .num_i   ('0),
      .rem_i   (rem_init[l]),
      .den_i   (dim[l]),
      .quo_o   (uv_quo[l]),
      .rem_o   (),
      .done_o  (uv_done[l])
    );
  end

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ch.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mcnt_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            state_q <= ST_MULX;
            mcnt_q  <= McntW'(FrameW);
          end
        end
        ST_MULX: begin
          if (mcnt_q != '0) begin
            mcnt_q <= mcnt_q - McntW'(1);
          end else begin
            mcnt_q  <= McntW'(RowW);
            state_q <= (tex_w_q != '0) ? ST_DIVR : ST_MULY;
          end
        end
        ST_DIVR: begin
          if (row_done) begin
            state_q <= ST_MULY;
          end
        end
        ST_MULY: begin
          if (mcnt_q != '0) begin
            mcnt_q <= mcnt_q - McntW'(1);
          end else begin
            state_q <= ST_PREP;
          end
        end
        ST_PREP: state_q <= ST_DIVUV;
        ST_DIVUV: begin
          if (uv_done[0]) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mul_hi_q  <= '0;
      mul_lo_q  <= RowW'(frame_d);
      changed_q <= chg_d;
    end else if (mul_step) begin
      mul_hi_q <= mul_sum[DimW:1];
      mul_lo_q <= {mul_sum[0], mul_lo_q[RowW-1:1]};
    end else if (state_q == ST_MULX) begin
      x_q      <= x_sum;
      mul_hi_q <= '0;
      mul_lo_q <= '0;
    end else if ((state_q == ST_DIVR) && row_done) begin
      x_q      <= XW'(row_rem);
      mul_hi_q <= '0;
      mul_lo_q <= row_quo;
    end else if (state_q == ST_MULY) begin
      y_q <= y_sum;
    end else if (state_q == ST_PREP) begin
      sat_q <= sat_d;
      msb_q <= ge_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_frame_q   <= frame_q;
      o_changed_q <= changed_q;
      for (int l = 0; l < Lanes; l++) begin
        o_uv_q[l] <= sat_q[l] ? sfuv_pkg::UvSat : {msb_q[l], uv_quo[l]};
      end
    end
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.frame         = o_frame_q;
  assign out_ch.frame_changed = o_changed_q;
  assign out_ch.u_min         = o_uv_q[0];
  assign out_ch.u_max         = o_uv_q[1];
  assign out_ch.v_min         = o_uv_q[2];
  assign out_ch.v_max         = o_uv_q[3];

  a_frame_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, frame_q} < eff_cnt)
    else $error("Current frame is outside the active frame count.");

  a_uv_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    uv_done[0] |-> (uv_done == {Lanes{1'b1}}))
    else $error("UV dividers finished out of step.");

  a_row_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_done |-> (state_q == ST_DIVR))
    else $error("Row division finished outside its state.");

  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.frame)
      && $stable(out_ch.frame_changed) && $stable(out_ch.u_min) && $stable(out_ch.u_max)
      && $stable(out_ch.v_min) && $stable(out_ch.v_max)))
    else $error("Pending result was dropped or overwritten.");

endmodule
